// File: src/lfpm_pkg.sv
package lfpm_pkg;

	// screen and driver geometry
	localparam int ROWS = 11;
	localparam int COLS = 42;
	localparam int CHIPS = 6;
	localparam int COLS_PER_CHIP = 7;

	localparam int DEPTH = ROWS * COLS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int COL_W = $clog2(COLS + 1);
	localparam int ROW_W = $clog2(ROWS + 1);

	// pwm register map of one driver chip
	localparam int PWM_REGS = 192;
	localparam int SW_PER_CS = 12;

	// reg / 12 as multiply and shift, exact for 8-bit reg
	localparam int DIV12_MUL = 171;
	localparam int DIV12_SHIFT = 11;

	// p / 255 as multiply and shift, exact for 16-bit p
	localparam int DIV255_MUL = 32897;
	localparam int DIV255_SHIFT = 23;

	localparam logic [7:0] BRIGHT_RESET = 8'd128;

	typedef enum logic [2:0] {
		OP_SET  = 3'd0,
		OP_GET  = 3'd1,
		OP_RECT = 3'd2,
		OP_ALL  = 3'd3,
		OP_PWM  = 3'd4
	} op_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic res_init;
		logic inb;
		logic set_write;
		logic fault;
		logic rd_pix;
		logic rd_pwm;
		logic walk_rect;
		logic walk_all;
		logic walk_step;
		logic take_pix;
		logic take_prod;
		logic scale;
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [2:0] op;
		logic       pos_ok;
		logic       rect_go;
		logic       walk_last;
		logic       out_free;
	} sts_t;

endpackage

// File: src/led_framebuffer_pwm_mapper_core.sv
// channel   signals                        direction
// input     in_valid / in_stall + fields   item in, stall out
// output    out_valid / out_stall + fields item out, stall in
// config    cfg_wr_en / cfg_wr_data        global brightness write
//
// one item at a time; from accept, set and idle opcodes pass EXEC and RESULT, get adds READ,
// pwm read adds READ and MUL (memory read, multiply, divide by 255), rectangle walks its
// clipped w*h area and fill all the store in FILL, one pixel per cycle through the write port
// after reset a clearing pass writes zero to all ROWS*COLS pixels, in_stall high
// a new item is taken while the previous result waits in the output register
module led_framebuffer_pwm_mapper_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [7:0]  x_pos,
	input  logic [7:0]  y_pos,
	input  logic [7:0]  rect_width,
	input  logic [7:0]  rect_height,
	input  logic [7:0]  level,
	input  logic [2:0]  chip_index,
	input  logic [7:0]  pwm_reg,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  read_data,
	output logic        in_bounds,
	output logic        error_flag,
	output logic [31:0] error_count
);
	import lfpm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer
	lfpm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// store, mapping and result registers
	lfpm_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.opcode      (opcode),
		.x_pos       (x_pos),
		.y_pos       (y_pos),
		.rect_width  (rect_width),
		.rect_height (rect_height),
		.level       (level),
		.chip_index  (chip_index),
		.pwm_reg     (pwm_reg),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.read_data   (read_data),
		.in_bounds   (in_bounds),
		.error_flag  (error_flag),
		.error_count (error_count)
	);

endmodule

// File: src/lfpm_ctrl.sv
module lfpm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  lfpm_pkg::sts_t  sts,
	output lfpm_pkg::cmd_t  cmd
);
	import lfpm_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_READ,
		S_MUL,
		S_FILL,
		S_RESULT
	} state_t;

	state_t state_q;

	assign in_stall = (state_q != S_IDLE);

	// command decode
	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.walk_step = 1'b1;
			end
			S_IDLE: begin
				cmd.capture = in_valid;
			end
			S_EXEC: begin
				cmd.res_init = 1'b1;
				case (sts.op)
					OP_SET: begin
						cmd.inb = sts.pos_ok;
						cmd.set_write = sts.pos_ok;
						cmd.fault = !sts.pos_ok;
					end
					OP_GET: begin
						cmd.inb = sts.pos_ok;
						cmd.rd_pix = 1'b1;
					end
					OP_RECT: begin
						cmd.walk_rect = sts.rect_go;
					end
					OP_ALL: begin
						cmd.walk_all = 1'b1;
					end
					OP_PWM: begin
						cmd.rd_pwm = 1'b1;
					end
					default: begin
					end
				endcase
			end
			S_READ: begin
				cmd.take_pix = (sts.op == OP_GET);
				cmd.take_prod = (sts.op == OP_PWM);
			end
			S_MUL: begin
				cmd.scale = 1'b1;
			end
			S_FILL: begin
				cmd.walk_step = 1'b1;
			end
			S_RESULT: begin
				cmd.load_out = sts.out_free;
			end
			default: begin
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (sts.walk_last) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) state_q <= S_EXEC;
				end
				S_EXEC: begin
					case (sts.op)
						OP_GET:  state_q <= S_READ;
						OP_PWM:  state_q <= S_READ;
						OP_RECT: state_q <= sts.rect_go ? S_FILL : S_RESULT;
						OP_ALL:  state_q <= S_FILL;
						default: state_q <= S_RESULT;
					endcase
				end
				S_READ: begin
					state_q <= (sts.op == OP_PWM) ? S_MUL : S_RESULT;
				end
				S_MUL: begin
					state_q <= S_RESULT;
				end
				S_FILL: begin
					if (sts.walk_last) state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (sts.out_free) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: src/lfpm_dp.sv
module lfpm_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  lfpm_pkg::cmd_t  cmd,
	output lfpm_pkg::sts_t  sts,
	input  logic            cfg_wr_en,
	input  logic [7:0]      cfg_wr_data,
	input  logic [2:0]      opcode,
	input  logic [7:0]      x_pos,
	input  logic [7:0]      y_pos,
	input  logic [7:0]      rect_width,
	input  logic [7:0]      rect_height,
	input  logic [7:0]      level,
	input  logic [2:0]      chip_index,
	input  logic [7:0]      pwm_reg,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [7:0]      read_data,
	output logic            in_bounds,
	output logic            error_flag,
	output logic [31:0]     error_count
);
	import lfpm_pkg::*;

	localparam logic [15:0] COLS_W = 16'(COLS);

	// captured item fields
	logic [2:0] op_q;
	logic [7:0] x_q, y_q, w_q, h_q, lvl_q, reg_q;
	logic [2:0] chip_q;

	// configuration and error state
	logic [7:0]  bright_q;
	logic        fault_q;
	logic [31:0] err_cnt_q;

	// pixel store
	logic [7:0] mem [DEPTH];
	logic [7:0] rd_q;
	logic       mem_we;
	logic [ADDR_W-1:0] mem_wa;
	logic [7:0] mem_wd;
	logic       mem_re;
	logic [ADDR_W-1:0] mem_ra;

	// fill walker
	logic [COL_W-1:0]  c_q, x0_q, x2_q, c_nx;
	logic [ROW_W-1:0]  r_q, y2_q, r_nx;
	logic [ADDR_W-1:0] base_q, walk_addr;
	logic [7:0]        fill_lvl_q;
	logic              walk_last;

	// result path
	logic        ok_q;
	logic [15:0] prod_q;
	logic [31:0] scaled;
	logic [7:0]  res_data_q;
	logic        res_inb_q;
	logic        out_valid_q;
	logic        out_free;

	// position check and pixel address
	logic        pos_ok;
	logic [15:0] pix_sum;
	logic [ADDR_W-1:0] pix_addr;
	logic [8:0]  x_end, y_end, x_lim, y_lim;
	logic        rect_go;

	// pwm register mapping
	logic [15:0] q12;
	logic [7:0]  cs, sw, col;
	logic [15:0] pwm_sum;
	logic [ADDR_W-1:0] pwm_addr;
	logic        pwm_ok;

	always_comb begin
		pos_ok = (x_q < 8'(COLS)) && (y_q < 8'(ROWS));
		pix_sum = {8'd0, y_q} * COLS_W + {8'd0, x_q};
		pix_addr = pix_sum[ADDR_W-1:0];

		x_end = {1'b0, x_q} + {1'b0, w_q};
		y_end = {1'b0, y_q} + {1'b0, h_q};
		x_lim = (x_end < 9'(COLS)) ? x_end : 9'(COLS);
		y_lim = (y_end < 9'(ROWS)) ? y_end : 9'(ROWS);
		rect_go = pos_ok && (w_q != 8'd0) && (h_q != 8'd0);

		q12 = {8'd0, reg_q} * 16'(DIV12_MUL);
		cs = 8'(q12 >> DIV12_SHIFT);
		sw = reg_q - 8'(cs * 8'(SW_PER_CS));
		col = 8'((8'(CHIPS - 1) - {5'd0, chip_q}) * 8'(COLS_PER_CHIP)) + cs;
		pwm_ok = ({5'd0, chip_q} < 8'(CHIPS)) && (reg_q < 8'(PWM_REGS))
			&& (cs < 8'(COLS_PER_CHIP)) && (sw < 8'(ROWS)) && (col < 8'(COLS));
		pwm_sum = {8'd0, sw} * COLS_W + {8'd0, col};
		pwm_addr = pwm_sum[ADDR_W-1:0];
	end

	// walker next position
	always_comb begin
		c_nx = c_q + COL_W'(1);
		r_nx = r_q + ROW_W'(1);
		walk_addr = base_q + ADDR_W'(c_q);
		walk_last = (c_nx == x2_q) && (r_nx == y2_q);
	end

	// memory ports
	always_comb begin
		mem_we = cmd.set_write | cmd.walk_step;
		mem_wa = cmd.set_write ? pix_addr : walk_addr;
		mem_wd = cmd.set_write ? lvl_q : fill_lvl_q;
		mem_re = (cmd.rd_pix & pos_ok) | (cmd.rd_pwm & pwm_ok);
		mem_ra = cmd.rd_pwm ? pwm_addr : pix_addr;
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (mem_re) rd_q <= mem[mem_ra];
	end

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= opcode;
			x_q <= x_pos;
			y_q <= y_pos;
			w_q <= rect_width;
			h_q <= rect_height;
			lvl_q <= level;
			chip_q <= chip_index;
			reg_q <= pwm_reg;
		end
	end

	// walker registers, reset to the clearing pass over the whole store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q <= '0;
			r_q <= '0;
			base_q <= '0;
			x0_q <= '0;
			x2_q <= COL_W'(COLS);
			y2_q <= ROW_W'(ROWS);
			fill_lvl_q <= 8'd0;
		end else if (cmd.walk_rect) begin
			c_q <= COL_W'(x_q);
			r_q <= ROW_W'(y_q);
			base_q <= ADDR_W'({8'd0, y_q} * COLS_W);
			x0_q <= COL_W'(x_q);
			x2_q <= COL_W'(x_lim);
			y2_q <= ROW_W'(y_lim);
			fill_lvl_q <= lvl_q;
		end else if (cmd.walk_all) begin
			c_q <= '0;
			r_q <= '0;
			base_q <= '0;
			x0_q <= '0;
			x2_q <= COL_W'(COLS);
			y2_q <= ROW_W'(ROWS);
			fill_lvl_q <= lvl_q;
		end else if (cmd.walk_step) begin
			if (c_nx == x2_q) begin
				c_q <= x0_q;
				r_q <= r_nx;
				base_q <= base_q + ADDR_W'(COLS);
			end else begin
				c_q <= c_nx;
			end
		end
	end

	// brightness register and error record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_q <= BRIGHT_RESET;
			fault_q <= 1'b0;
			err_cnt_q <= '0;
		end else begin
			if (cfg_wr_en) bright_q <= cfg_wr_data;
			if (cmd.fault) begin
				fault_q <= 1'b1;
				err_cnt_q <= err_cnt_q + 32'd1;
			end
		end
	end

	// result forming: pixel read, then product and divide by full scale
	assign scaled = {16'd0, prod_q} * 32'(DIV255_MUL);

	always_ff @(posedge clk) begin
		if (cmd.res_init) begin
			res_data_q <= 8'd0;
			res_inb_q <= cmd.inb;
		end
		if (cmd.rd_pix) ok_q <= pos_ok;
		if (cmd.rd_pwm) ok_q <= pwm_ok;
		if (cmd.take_pix) res_data_q <= ok_q ? rd_q : 8'd0;
		if (cmd.take_prod) prod_q <= {8'd0, rd_q} * {8'd0, bright_q};
		if (cmd.scale) res_data_q <= ok_q ? 8'(scaled >> DIV255_SHIFT) : 8'd0;
	end

	// output register
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			read_data <= res_data_q;
			in_bounds <= res_inb_q;
			error_flag <= fault_q;
			error_count <= err_cnt_q;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		sts.op = op_q;
		sts.pos_ok = pos_ok;
		sts.rect_go = rect_go;
		sts.walk_last = walk_last;
		sts.out_free = out_free;
	end

endmodule
